FILE: sv/cts_pkg.sv
// ----------------------------------------------------------------------------
// Cosine transform spectrum package
// Shared types, command codes, default sizes and the cosine table builder.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Default sizes handed to the top level.
    localparam int unsigned MAX_POINTS_DEF     = 1024;
    localparam int unsigned COS_TABLE_BITS_DEF = 10;

    // Command codes carried on the cmd field.
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Pi/2 in Q30, used to place the table points.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Output saturation limits (52-bit signed range).
    localparam logic signed [63:0] SPEC_MAX = 64'sd2251799813685247;
    localparam logic signed [63:0] SPEC_MIN = -64'sd2251799813685248;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append_wr;   // write one point at the write address
        logic start;       // latch the bin and clear the accumulator
        logic load_kstep;  // form bin times phase step
        logic issue;       // read one point at the read address
        logic load_out;    // load the saturated sum into the output register
    } cts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;   // points still travelling through the pipeline
    } cts_status_t;

    // One quarter-wave cosine entry, unsigned Q1.17, from a Q30 Taylor series.
    function automatic logic [17:0] cos_entry(input int unsigned idx,
                                              input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (HALF_PI_Q30 * 64'(idx)) >> bits;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd2;
                2:       term = term / 64'd12;
                3:       term = term / 64'd30;
                4:       term = term / 64'd56;
                5:       term = term / 64'd90;
                6:       term = term / 64'd132;
                7:       term = term / 64'd182;
                8:       term = term / 64'd240;
                9:       term = term / 64'd306;
                default: term = term / 64'd380;
            endcase
            if ((n % 2) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        // Round half up to Q17 and clamp to the range of a cosine.
        r = sum + 64'sd4096;
        if (r < 0)
            r = 64'sd0;
        else
            r = r >>> 13;
        if (r > 64'sd131072)
            r = 64'sd131072;
        return r[17:0];
    endfunction

endpackage

FILE: sv/cts_ctrl.sv
// ----------------------------------------------------------------------------
// Cosine transform spectrum controller
// Handles the input handshake, keeps the point count and sequences a compute
// request through the datapath one point per cycle.
// ----------------------------------------------------------------------------
module cts_ctrl #(
    parameter int unsigned MAX_POINTS = cts_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    output logic                            out_valid,
    input  logic                            out_stall,
    output cts_pkg::cts_cmd_t               dp_cmd,
    input  cts_pkg::cts_status_t            dp_status,
    output logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0]   rd_addr
);
    import cts_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_cnt_reg, rd_cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = rd_cnt_reg[AW-1:0];

    // Next state, counters and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        out_valid_next = out_valid_reg;
        dp_cmd         = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CW'(MAX_POINTS))
                            begin
                                dp_cmd.append_wr = 1'b1;
                                count_next       = count_reg + 1'b1;
                            end
                        end
                        CMD_COMPUTE:
                        begin
                            dp_cmd.start = 1'b1;
                            state_next   = ST_SETUP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                dp_cmd.load_kstep = 1'b1;
                rd_cnt_next       = '0;
                state_next        = (count_reg == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                dp_cmd.issue = 1'b1;
                rd_cnt_next  = rd_cnt_reg + 1'b1;
                if ((rd_cnt_reg + 1'b1) == count_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!dp_status.pipe_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Wait for the output register to be free.
                if (!out_valid_reg || !out_stall)
                begin
                    dp_cmd.load_out = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/cts_datapath.sv
// ----------------------------------------------------------------------------
// Cosine transform spectrum datapath
// Point store, phase step register, phase multiplier, cosine table and the
// multiply-accumulate pipeline with output saturation.
// ----------------------------------------------------------------------------
module cts_datapath #(
    parameter int unsigned MAX_POINTS     = cts_pkg::MAX_POINTS_DEF,
    parameter int unsigned COS_TABLE_BITS = cts_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            phase_step_wr_en,
    input  logic [31:0]                     phase_step_wr_data,
    input  logic [23:0]                     sample_time,
    input  logic signed [23:0]              sample_value,
    input  logic [15:0]                     bin_index,
    input  cts_pkg::cts_cmd_t               dp_cmd,
    output cts_pkg::cts_status_t            dp_status,
    input  logic [$clog2(MAX_POINTS)-1:0]   wr_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]   rd_addr,
    output logic [15:0]                     result_bin,
    output logic signed [51:0]              spectrum_value
);
    import cts_pkg::*;

    localparam int unsigned B    = COS_TABLE_BITS;
    localparam int unsigned QTR  = 1 << B;
    localparam int unsigned SHFT = 29 - B;

    typedef logic [17:0] cos_rom_t [0:QTR];

    function automatic cos_rom_t build_rom();
        cos_rom_t rom;
        for (int i = 0; i <= int'(QTR); i++)
            rom[i] = cos_entry(i, B);
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_rom();

    // Point store.
    logic [23:0]        time_mem  [0:MAX_POINTS-1];
    logic [23:0]        value_mem [0:MAX_POINTS-1];

    logic [31:0]        phase_step_reg;
    logic [15:0]        bin_reg;
    logic [31:0]        kstep_reg;
    logic [23:0]        time_rd_reg;
    logic [23:0]        value_rd_reg;
    logic [31:0]        phase_reg;
    logic signed [23:0] value_p2_reg;
    logic [17:0]        cos_reg;
    logic               neg_reg;
    logic signed [23:0] value_p3_reg;
    logic signed [42:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [15:0]        result_bin_reg;
    logic signed [51:0] spectrum_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;

    logic [B+2:0]       phase_sh;
    logic [B+2:0]       phase_rnd;
    logic [B+1:0]       tab_a;
    logic [1:0]         quad;
    logic [B-1:0]       tab_j;
    logic [B:0]         rom_idx;
    logic signed [42:0] prod_next;
    logic signed [63:0] sat_next;

    // Nearest table step, quadrant and mirrored index.
    assign phase_sh  = phase_reg[SHFT+B+2:SHFT];
    assign phase_rnd = phase_sh + 1'b1;
    assign tab_a     = phase_rnd[B+2:1];
    assign quad      = tab_a[B+1:B];
    assign tab_j     = tab_a[B-1:0];
    assign rom_idx   = quad[0] ? ((B+1)'(QTR) - {1'b0, tab_j}) : {1'b0, tab_j};

    // Signed product of the value and the cosine magnitude.
    assign prod_next = neg_reg ?
        -(43'(value_p3_reg) * $signed({25'd0, cos_reg})) :
        (43'(value_p3_reg) * $signed({25'd0, cos_reg}));

    // Saturation of the sum to the output range.
    always_comb
    begin
        if (acc_reg > SPEC_MAX)
            sat_next = SPEC_MAX;
        else if (acc_reg < SPEC_MIN)
            sat_next = SPEC_MIN;
        else
            sat_next = acc_reg;
    end

    assign dp_status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign result_bin          = result_bin_reg;
    assign spectrum_value      = spectrum_reg;

    // Store write and registered read.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.append_wr)
        begin
            time_mem[wr_addr]  <= sample_time;
            value_mem[wr_addr] <= sample_value;
        end
        if (dp_cmd.issue)
        begin
            time_rd_reg  <= time_mem[rd_addr];
            value_rd_reg <= value_mem[rd_addr];
        end
    end

    // Payload pipeline: phase, table read, product and output.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
            bin_reg <= bin_index;
        if (dp_cmd.load_kstep)
            kstep_reg <= 32'(bin_reg * phase_step_reg);
        phase_reg    <= kstep_reg * 32'(time_rd_reg);
        value_p2_reg <= $signed(value_rd_reg);
        cos_reg      <= COS_ROM[rom_idx];
        neg_reg      <= (quad == 2'd1) || (quad == 2'd2);
        value_p3_reg <= value_p2_reg;
        prod_reg     <= prod_next;
        if (dp_cmd.load_out)
        begin
            result_bin_reg <= bin_reg;
            spectrum_reg   <= sat_next[51:0];
        end
    end

    // Control registers: phase step, stage valids and accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            if (phase_step_wr_en)
                phase_step_reg <= phase_step_wr_data;
            v1_reg <= dp_cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (dp_cmd.start)
                acc_reg <= '0;
            else if (v4_reg)
                acc_reg <= acc_reg + 64'(prod_reg);
        end
    end

endmodule

FILE: sv/cosine_transform_spectrum_top.sv
// Sequence: clear and append are taken while idle; a compute beat passes setup, a read
// per stored point, drain and finish; input stays stalled until its result is presented.
// Throughput: one stored point per cycle through the multiply-accumulate pipe,
// set by the single read port of the point store; one request at a time.
// Reset: point count, phase step and handshake state clear; the point store
// holds no reset value and is only read below the point count.
// ----------------------------------------------------------------------------
// Cosine transform spectrum top level
// Point store with a per-bin cosine-weighted sum over all stored points.
// ----------------------------------------------------------------------------
module cosine_transform_spectrum_top #(
    parameter int unsigned MAX_POINTS     = cts_pkg::MAX_POINTS_DEF,
    parameter int unsigned COS_TABLE_BITS = cts_pkg::COS_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               phase_step_wr_en,
    input  logic [31:0]        phase_step_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [23:0]        sample_time,
    input  logic signed [23:0] sample_value,
    input  logic [15:0]        bin_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        result_bin,
    output logic signed [51:0] spectrum_value
);
    import cts_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);

    cts_cmd_t    dp_cmd;
    cts_status_t dp_status;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Sequencer.
    cts_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr)
    );

    // Store and arithmetic.
    cts_datapath #(
        .MAX_POINTS     (MAX_POINTS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .phase_step_wr_en   (phase_step_wr_en),
        .phase_step_wr_data (phase_step_wr_data),
        .sample_time        (sample_time),
        .sample_value       (sample_value),
        .bin_index          (bin_index),
        .dp_cmd             (dp_cmd),
        .dp_status          (dp_status),
        .wr_addr            (wr_addr),
        .rd_addr            (rd_addr),
        .result_bin         (result_bin),
        .spectrum_value     (spectrum_value)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine transform spectrum testbench
// Drives clear, append and compute beats through several phase-step settings
// and idling patterns, predicts each bin sum from a local cosine table and
// point store, and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
    import cts_pkg::*;

    localparam int unsigned NPTS  = 1024;
    localparam int unsigned TBITS = 10;
    localparam int unsigned QLEN  = 1 << TBITS;
    localparam longint      LIMIT = 4000000;
    localparam longint      SUM_HI = 64'sd2251799813685247;
    localparam longint      SUM_LO = -64'sd2251799813685248;

    typedef struct packed {
        logic [1:0]         op;
        logic [23:0]        t;
        logic signed [23:0] v;
        logic [15:0]        k;
    } beat_t;

    typedef struct packed {
        logic [15:0]        k;
        logic signed [51:0] s;
    } spec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               phase_step_wr_en = 1'b0;
    logic [31:0]        phase_step_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_CLEAR;
    logic [23:0]        sample_time = '0;
    logic signed [23:0] sample_value = '0;
    logic [15:0]        bin_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        result_bin;
    logic signed [51:0] spectrum_value;

    beat_t       pending_beats[$];
    spec_t       expected_spectra[$];
    int          errors = 0;
    int          computes_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycles = 0;

    // Local copy of the block's state.
    logic [17:0] cos_q17[QLEN + 1];
    logic [31:0] step_mirror = '0;
    logic [23:0] times[NPTS];
    logic [23:0] values[NPTS];
    int unsigned stored = 0;

    cosine_transform_spectrum_top dut (.*);

    always #5 clk = ~clk;

    // Quarter-wave cosine table, Q1.17, from a Q30 Taylor series.
    function automatic void build_cosines();
        longint unsigned x, x2, term;
        longint          acc, r;
        for (int i = 0; i <= QLEN; i++)
        begin
            x    = (64'd1686629713 * i) >> TBITS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = 1 << 30;
            for (int n = 1; n <= 10; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    acc -= longint'(term);
                else
                    acc += longint'(term);
            end
            r = acc + 4096;
            r = (r < 0) ? 0 : r / 8192;
            if (r > 131072)
                r = 131072;
            cos_q17[i] = r[17:0];
        end
    endfunction

    function automatic longint cosine_at(logic [31:0] phase);
        logic [31:0] a;
        logic [1:0]  quad;
        int unsigned j;
        a    = (((phase >> (29 - TBITS)) + 1) >> 1) & ((QLEN << 2) - 1);
        quad = a[TBITS +: 2];
        j    = a & (QLEN - 1);
        case (quad)
            2'd0:    return longint'(cos_q17[j]);
            2'd1:    return -longint'(cos_q17[QLEN - j]);
            2'd2:    return -longint'(cos_q17[j]);
            default: return longint'(cos_q17[QLEN - j]);
        endcase
    endfunction

    // Apply one accepted beat to the local state; compute beats yield a sum.
    function automatic void apply_beat(beat_t b);
        logic [31:0] kstep;
        logic [31:0] phase;
        longint      acc;
        spec_t       e;
        case (b.op)
            CMD_CLEAR: stored = 0;
            CMD_APPEND:
                if (stored < NPTS)
                begin
                    times[stored]  = b.t;
                    values[stored] = b.v;
                    stored++;
                end
            CMD_COMPUTE:
            begin
                kstep = 32'(64'(b.k) * 64'(step_mirror));
                acc   = 0;
                for (int p = 0; p < stored; p++)
                begin
                    phase = 32'(64'(kstep) * 64'(times[p]));
                    acc  += longint'($signed(values[p])) * cosine_at(phase);
                end
                if (acc > SUM_HI)
                    acc = SUM_HI;
                if (acc < SUM_LO)
                    acc = SUM_LO;
                e.k = b.k;
                e.s = acc[51:0];
                expected_spectra.push_back(e);
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Driver: once the current beat has gone, offers the next one or idles at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                apply_beat('{cmd, sample_time, sample_value, bin_index});
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_t b;
                    b = pending_beats.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= b.op;
                    sample_time  <= b.t;
                    sample_value <= b.v;
                    bin_index    <= b.k;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls, and each result beat checked against the oldest sum.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_spectra.size() == 0)
                    report("unexpected beat", 64'(result_bin), 64'd0);
                else
                begin
                    spec_t e;
                    e = expected_spectra.pop_front();
                    computes_seen++;
                    if (result_bin !== e.k)
                        report("result_bin", 64'(result_bin), 64'(e.k));
                    if (spectrum_value !== e.s)
                        report("spectrum_value", 64'(spectrum_value), 64'(e.s));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_beat(logic [1:0] op, logic [23:0] t, logic [23:0] v, logic [15:0] k);
        pending_beats.push_back('{op, t, v, k});
    endtask

    task automatic wait_idle();
        wait (pending_beats.size() == 0 && !in_valid && expected_spectra.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_step(logic [31:0] value);
        @(posedge clk);
        phase_step_wr_en   <= 1'b1;
        phase_step_wr_data <= value;
        step_mirror = value;
        @(posedge clk);
        phase_step_wr_en <= 1'b0;
    endtask

    // Well-formed runs: a clear, a few appends, then several bins; some noise.
    task automatic random_beats(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                push_beat(2'($urandom_range(3)), 24'($urandom), 24'($urandom),
                          16'($urandom));
                n++;
            end
            else
            begin
                push_beat(CMD_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom));
                repeat ($urandom_range(12)) push_beat(CMD_APPEND, 24'($urandom),
                                                      24'($urandom), 16'($urandom));
                repeat ($urandom_range(1, 4)) push_beat(CMD_COMPUTE, 24'($urandom),
                                                        24'($urandom), 16'($urandom));
                n += 8;
            end
        end
    endtask

    initial
    begin
        build_cosines();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, field extremes, unknown command, reset step of zero.
        push_beat(CMD_COMPUTE, '0, '0, 16'd0);
        push_beat(CMD_APPEND, 24'h000000, 24'h7FFFFF, 16'hFFFF);
        push_beat(CMD_APPEND, 24'hFFFFFF, 24'h800000, 16'h0000);
        push_beat(CMD_APPEND, 24'h000100, 24'hFFFFFF, 16'h1234);
        push_beat(2'd3, 24'hFFFFFF, 24'h7FFFFF, 16'hFFFF);
        push_beat(CMD_COMPUTE, '0, '0, 16'hFFFF);
        wait_idle();
        write_step(32'hFFFFFFFF);
        push_beat(CMD_COMPUTE, '0, '0, 16'h0000);
        push_beat(CMD_COMPUTE, '0, '0, 16'hFFFF);
        push_beat(CMD_COMPUTE, '0, '0, 16'h0001);
        push_beat(CMD_CLEAR, '0, '0, '0);
        push_beat(CMD_COMPUTE, '0, '0, 16'h0005);
        wait_idle();

        // Fill the store to capacity, then one dropped append and two bins.
        write_step(32'h0001_0000);
        for (int i = 0; i < NPTS + 1; i++)
            push_beat(CMD_APPEND, 24'($urandom), 24'($urandom | 24'h7F0000), '0);
        push_beat(CMD_COMPUTE, '0, '0, 16'd0);
        push_beat(CMD_COMPUTE, '0, '0, 16'($urandom));
        push_beat(CMD_CLEAR, '0, '0, '0);
        wait_idle();

        // Random phases: idling patterns combined with different steps.
        send_idle_pct = 0;  recv_stall_pct = 0;
        write_step($urandom);
        random_beats(125);
        wait_idle();
        send_idle_pct = 45; recv_stall_pct = 0;
        write_step(32'hFFFFFFFF);
        random_beats(125);
        wait_idle();
        send_idle_pct = 0;  recv_stall_pct = 45;
        write_step(32'd0);
        random_beats(125);
        wait_idle();
        send_idle_pct = 36; recv_stall_pct = 36;
        write_step($urandom);
        random_beats(125);
        wait_idle();

        $display("run covered clear, append, compute and unknown commands over six steps,");
        $display("a full store and four idling patterns; %0d bin sums checked", computes_seen);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
